/* src/lts_pkg.sv */
package lts_pkg;

    localparam int MAX_NODES_DEF = 16;
    localparam int RUN_LIMIT = 16;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int NODE_W = 4;
    localparam int LAYER_W = 4;
    localparam int COUNT_W = 5;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_RUN = 1'b1;

    localparam logic REG_NODE_COUNT = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic              kind;
        logic [NODE_W-1:0] row_node;
        logic [NODE_W-1:0] col_node;
        logic              edge_bit;
    } item_t;

    typedef struct packed {
        logic               valid;
        logic [NODE_W-1:0]  node_index;
        logic [LAYER_W-1:0] layer;
        logic               cycle_error;
        logic               last;
    } result_t;

endpackage

/* src/lts_apb.sv */
module lts_apb
    import lts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [COUNT_W-1:0]    node_count
);

    logic [COUNT_W-1:0] node_count_reg;
    logic               reg_sel;

    assign reg_sel = (paddr[APB_ADDR_W-1] == REG_NODE_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            node_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = reg_sel ? APB_DATA_W'(node_count_reg) : '0;
    assign node_count = node_count_reg;

endmodule

/* src/lts_dep_mem.sv */
module lts_dep_mem
    import lts_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
    output logic [MAX_NODES-1:0]         rd_data,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
    input  logic [MAX_NODES-1:0]         wr_data
);

    logic [MAX_NODES-1:0] mem_reg [MAX_NODES];
    logic [MAX_NODES-1:0] rd_data_reg;
    logic [MAX_NODES-1:0] row_valid_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    // Rows never written read as zero, which is the reset contents.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* src/lts_ctrl.sv */
module lts_ctrl
    import lts_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  item_t                        item,
    input  logic [COUNT_W-1:0]           node_count,
    output logic                         busy,
    output result_t                      result,
    output logic                         rd_en,
    output logic [$clog2(MAX_NODES)-1:0] rd_addr,
    input  logic [MAX_NODES-1:0]         rd_data,
    output logic                         wr_en,
    output logic [$clog2(MAX_NODES)-1:0] wr_addr,
    output logic [MAX_NODES-1:0]         wr_data
);

    localparam int LIM = (MAX_NODES < RUN_LIMIT) ? MAX_NODES : RUN_LIMIT;
    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(LIM + 1);
    localparam int CHK_W = $clog2(LIM);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [CHK_W-1:0]     chk_idx_reg, chk_idx_next;
    logic [MAX_NODES-1:0] remaining_reg, remaining_next;
    logic [MAX_NODES-1:0] ready_acc_reg, ready_acc_next;
    logic                 all_ready_reg, all_ready_next;
    logic [LAYER_W-1:0]   layer_reg, layer_next;
    logic [IDX_W-1:0]     wr_row_reg, wr_row_next;
    logic [IDX_W-1:0]     wr_col_reg, wr_col_next;
    logic                 wr_set_reg, wr_set_next;
    result_t              result_reg, result_next;

    logic                 accept;
    logic                 addr_ok;
    logic [CNT_W-1:0]     n_eff;
    logic [MAX_NODES-1:0] active;
    logic                 scan_last;
    logic                 node_rem;
    logic                 node_ready;
    logic                 none_above;
    logic                 all_ready_now;
    logic [MAX_NODES-1:0] node_bit;
    logic [MAX_NODES-1:0] ready_now;
    logic [MAX_NODES-1:0] remaining_after;
    logic [MAX_NODES-1:0] col_mask;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy = (state_reg != ST_IDLE);
    assign addr_ok = (int'(item.row_node) < MAX_NODES) && (int'(item.col_node) < MAX_NODES);
    assign n_eff = (int'(node_count) > LIM) ? CNT_W'(LIM) : CNT_W'(node_count);

    always_comb
    begin
        for (int k = 0; k < MAX_NODES; k++)
        begin
            active[k] = (k < int'(n_eff));
        end
    end

    assign scan_last = chk_vld_reg && (CNT_W'(chk_idx_reg) == n_reg - CNT_W'(1));
    assign node_bit = MAX_NODES'(1) << chk_idx_reg;
    assign node_rem = remaining_reg[IDX_W'(chk_idx_reg)];
    assign node_ready = chk_vld_reg && node_rem && ((rd_data & remaining_reg) == '0);
    assign none_above = ((remaining_reg >> chk_idx_reg) >> 1) == '0;
    assign all_ready_now = all_ready_reg && (!chk_vld_reg || !node_rem || node_ready);
    assign ready_now = ready_acc_reg | (node_ready ? node_bit : '0);
    assign remaining_after = remaining_reg & ~ready_now;
    assign col_mask = MAX_NODES'(1) << wr_col_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.kind)
                        KIND_WRITE: state_next = addr_ok ? ST_WRITE : ST_IDLE;
                        KIND_RUN:   state_next = (n_eff != '0) ? ST_SCAN : ST_IDLE;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_last && ((ready_now == '0) || (remaining_after == '0)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        n_next = n_reg;
        rd_idx_next = rd_idx_reg;
        chk_vld_next = 1'b0;
        chk_idx_next = chk_idx_reg;
        remaining_next = remaining_reg;
        ready_acc_next = ready_acc_reg;
        all_ready_next = all_ready_reg;
        layer_next = layer_reg;
        wr_row_next = wr_row_reg;
        wr_col_next = wr_col_reg;
        wr_set_next = wr_set_reg;
        result_next = '0;
        rd_en = 1'b0;
        rd_addr = IDX_W'(rd_idx_reg);
        wr_en = 1'b0;
        wr_addr = wr_row_reg;
        wr_data = wr_set_reg ? (rd_data | col_mask) : (rd_data & ~col_mask);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.kind == KIND_WRITE))
                begin
                    rd_en = addr_ok;
                    rd_addr = IDX_W'(item.row_node);
                    wr_row_next = IDX_W'(item.row_node);
                    wr_col_next = IDX_W'(item.col_node);
                    wr_set_next = item.edge_bit;
                end
                else if (accept)
                begin
                    n_next = n_eff;
                    remaining_next = active;
                    ready_acc_next = '0;
                    all_ready_next = 1'b1;
                    layer_next = '0;
                    rd_idx_next = '0;
                end
            end
            ST_WRITE:
            begin
                wr_en = 1'b1;
            end
            ST_SCAN:
            begin
                if (rd_idx_reg < n_reg)
                begin
                    rd_en = 1'b1;
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    chk_vld_next = 1'b1;
                    chk_idx_next = CHK_W'(rd_idx_reg);
                end
                ready_acc_next = ready_now;
                all_ready_next = all_ready_now;
                if (node_ready)
                begin
                    result_next.valid = 1'b1;
                    result_next.node_index = NODE_W'(chk_idx_reg);
                    result_next.layer = layer_reg;
                    result_next.last = all_ready_now && none_above;
                end
                if (scan_last)
                begin
                    if (ready_now == '0)
                    begin
                        result_next.valid = 1'b1;
                        result_next.node_index = '0;
                        result_next.layer = layer_reg;
                        result_next.cycle_error = 1'b1;
                        result_next.last = 1'b1;
                    end
                    else
                    begin
                        remaining_next = remaining_after;
                        ready_acc_next = '0;
                        all_ready_next = 1'b1;
                        rd_idx_next = '0;
                        if (remaining_after != '0)
                        begin
                            layer_next = layer_reg + LAYER_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg <= '0;
            rd_idx_reg <= '0;
            chk_vld_reg <= 1'b0;
            chk_idx_reg <= '0;
            remaining_reg <= '0;
            ready_acc_reg <= '0;
            all_ready_reg <= 1'b1;
            layer_reg <= '0;
            result_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg <= n_next;
            rd_idx_reg <= rd_idx_next;
            chk_vld_reg <= chk_vld_next;
            chk_idx_reg <= chk_idx_next;
            remaining_reg <= remaining_next;
            ready_acc_reg <= ready_acc_next;
            all_ready_reg <= all_ready_next;
            layer_reg <= layer_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_row_reg <= wr_row_next;
        wr_col_reg <= wr_col_next;
        wr_set_reg <= wr_set_next;
    end

    assign result = result_reg;

endmodule

/* src/layered_topological_sort.sv */
// Layered topological sort over a dependency bit matrix held in a memory.
// Bit j of row i set means node i depends on node j.
// Configuration: one APB register at byte address 0, node_count. Write it only
// while busy is low.
// Commands: a transaction is accepted at a rising edge with start high and busy
// low. A write command (kind 0) sets or clears one bit with a read-modify-write
// of its row; busy is high while the row is written back.
// A run command (kind 1) sorts the first node_count nodes, at most MAX_NODES
// and RUN_LIMIT. Each layer is one pass over the rows, one row read per cycle.
// Results: result_valid marks each result transaction for exactly one cycle.
// Node results of a layer come in ascending index during that layer's pass,
// each registered after its row passes the memory read register; last marks
// the final result of the run. A cycle in the remaining nodes ends the run
// with one result flagged by cycle_error.
// The receiver cannot stall the results, and the final result of a run may
// still be on the ports in the cycle in which the next command is accepted.
// Reset clears the matrix, node_count and the control state but the write row, column and bit.
module layered_topological_sort
    import lts_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  start,
    output logic                  busy,
    input  logic                  kind,
    input  logic [NODE_W-1:0]     row_node,
    input  logic [NODE_W-1:0]     col_node,
    input  logic                  edge_bit,
    output logic                  result_valid,
    output logic [NODE_W-1:0]     node_index,
    output logic [LAYER_W-1:0]    layer,
    output logic                  cycle_error,
    output logic                  last
);

    localparam int IDX_W = $clog2(MAX_NODES);

    logic [COUNT_W-1:0]   node_count;
    item_t                item;
    result_t              result;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [MAX_NODES-1:0] rd_data;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [MAX_NODES-1:0] wr_data;

    assign item.kind = kind;
    assign item.row_node = row_node;
    assign item.col_node = col_node;
    assign item.edge_bit = edge_bit;

    lts_apb u_apb (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .node_count (node_count)
    );

    lts_dep_mem #(
        .MAX_NODES (MAX_NODES)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    lts_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .node_count (node_count),
        .busy       (busy),
        .result     (result),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    assign result_valid = result.valid;
    assign node_index = result.node_index;
    assign layer = result.layer;
    assign cycle_error = result.cycle_error;
    assign last = result.last;

endmodule

/* src/lts_checker.sv */
module lts_checker
    import lts_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              kind,
    input logic              result_valid,
    input logic [NODE_W-1:0] node_index,
    input logic              cycle_error,
    input logic              last
);

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && cycle_error) |-> last)
        else $error("Cycle error result without last.");

    a_error_node_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && cycle_error) |-> (node_index == '0))
        else $error("Cycle error result with a nonzero node index.");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |=> !result_valid)
        else $error("Result transaction directly after the last one of a run.");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_WRITE)) |=> !result_valid)
        else $error("Result transaction following a write command.");

endmodule

bind layered_topological_sort lts_checker u_lts_checker (.*);

/* tb/sv/layered_topological_sort_checker.sv */
`timescale 1ns / 1ps

module layered_topological_sort_checker
    import lts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  kind,
    input  logic [NODE_W-1:0]     row_node,
    input  logic [NODE_W-1:0]     col_node,
    input  logic                  edge_bit,
    input  logic                  result_valid,
    input  logic [NODE_W-1:0]     node_index,
    input  logic [LAYER_W-1:0]    layer,
    input  logic                  cycle_error,
    input  logic                  last,
    output int                    fail_count,
    output int                    pending
);

    localparam logic [APB_ADDR_W-1:0] NODE_COUNT_ADDR = APB_ADDR_W'(4 * REG_NODE_COUNT);

    logic [15:0]        dep_rows [16];
    logic [COUNT_W-1:0] node_limit;
    result_t            placements_due [$];

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        fail_count++;
    endtask

    // Kahn's algorithm, one layer per round, over the first node_limit nodes (at most 16).
    task automatic predict_layers();
        logic [15:0]        active;
        logic [15:0]        taken;
        logic [15:0]        remaining;
        logic [15:0]        ready;
        logic [LAYER_W-1:0] lvl;
        result_t            r;
        int                 n;
        n = (node_limit > 16) ? 16 : int'(node_limit);
        if (n == 0)
        begin
            return;
        end
        active = 16'((17'(1) << n) - 17'(1));
        taken = '0;
        lvl = '0;
        while ((taken & active) != active)
        begin
            remaining = active & ~taken;
            ready = '0;
            for (int i = 0; i < n; i++)
            begin
                if (remaining[i] && ((dep_rows[i] & remaining) == 16'd0))
                begin
                    ready[i] = 1'b1;
                end
            end
            if (ready == 16'd0)
            begin
                r = '{valid: 1'b1, node_index: '0, layer: lvl, cycle_error: 1'b1, last: 1'b1};
                placements_due = {placements_due, r};
                return;
            end
            for (int i = 0; i < n; i++)
            begin
                if (ready[i])
                begin
                    r = '{valid: 1'b1, node_index: NODE_W'(i), layer: lvl,
                          cycle_error: 1'b0, last: 1'b0};
                    placements_due = {placements_due, r};
                end
            end
            taken = taken | ready;
            lvl = lvl + 1'b1;
        end
        r = placements_due[$];
        r.last = 1'b1;
        placements_due[$] = r;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                dep_rows[i] = '0;
            end
            node_limit = '0;
            placements_due.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (placements_due.size() == 0)
                begin
                    report_mismatch($sformatf("result node %0d layer %0d with none expected",
                                              node_index, layer));
                end
                else
                begin
                    want = placements_due.pop_front();
                    if (node_index !== want.node_index)
                    begin
                        report_mismatch($sformatf("node_index got %0d want %0d",
                                                  node_index, want.node_index));
                    end
                    if (layer !== want.layer)
                    begin
                        report_mismatch($sformatf("layer got %0d want %0d",
                                                  layer, want.layer));
                    end
                    if (cycle_error !== want.cycle_error)
                    begin
                        report_mismatch($sformatf("cycle_error got %b want %b",
                                                  cycle_error, want.cycle_error));
                    end
                    if (last !== want.last)
                    begin
                        report_mismatch($sformatf("last got %b want %b", last, want.last));
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == NODE_COUNT_ADDR)
            begin
                node_limit = pwdata[COUNT_W-1:0];
            end
            if (start && !busy)
            begin
                if (kind == KIND_WRITE)
                begin
                    dep_rows[row_node][col_node] = edge_bit;
                end
                else
                begin
                    predict_layers();
                end
            end
            pending <= placements_due.size();
        end
    end

endmodule

/* tb/sv/layered_topological_sort_tb.sv */
`timescale 1ns / 1ps

module layered_topological_sort_tb;
    import lts_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 300;
    localparam int PHASE_ITEMS = 40;
    localparam logic [APB_ADDR_W-1:0] NODE_COUNT_ADDR = APB_ADDR_W'(4 * REG_NODE_COUNT);

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  kind = KIND_WRITE;
    logic [NODE_W-1:0]     row_node = '0;
    logic [NODE_W-1:0]     col_node = '0;
    logic                  edge_bit = 1'b0;
    logic                  result_valid;
    logic [NODE_W-1:0]     node_index;
    logic [LAYER_W-1:0]    layer;
    logic                  cycle_error;
    logic                  last;
    int                    fail_count;
    int                    pending;

    int          cycle_count = 0;
    int          items_sent = 0;
    bit          steady = 1'b0;
    logic [15:0] written [16];
    int          order_pos [16];
    int          undo_rows [$];
    int          undo_cols [$];
    int          node_counts [8] = '{16, 4, 1, 16, 0, 9, 2, 31};

    layered_topological_sort dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .kind(kind), .row_node(row_node), .col_node(col_node), .edge_bit(edge_bit),
        .result_valid(result_valid), .node_index(node_index), .layer(layer),
        .cycle_error(cycle_error), .last(last)
    );

    layered_topological_sort_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .start(start), .busy(busy),
        .kind(kind), .row_node(row_node), .col_node(col_node), .edge_bit(edge_bit),
        .result_valid(result_valid), .node_index(node_index), .layer(layer),
        .cycle_error(cycle_error), .last(last),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_command(input logic k, input int r, input int c, input logic e);
        if (!steady && $urandom_range(99) < 10)
        begin
            start <= 1'b0;
            repeat (($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 5))
            begin
                @(posedge clk);
            end
        end
        start <= 1'b1;
        kind <= k;
        row_node <= NODE_W'(r);
        col_node <= NODE_W'(c);
        edge_bit <= e;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        items_sent++;
    endtask

    task automatic set_edge(input int r, input int c, input logic e);
        send_command(KIND_WRITE, r, c, e);
        written[r][c] = e;
    endtask

    task automatic run_sort();
        send_command(KIND_RUN, $urandom_range(15), $urandom_range(15), 1'($urandom));
    endtask

    task automatic drain();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0 || busy);
        repeat (SETTLE_CYCLES)
        begin
            @(posedge clk);
        end
    endtask

    task automatic configure(input logic [APB_DATA_W-1:0] value);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= NODE_COUNT_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial
    begin
        int order [16];
        int span;
        int cfg;
        int phase_start;
        int pick;
        int a;
        int b;
        int tmp;
        int tries;
        logic e;

        for (int i = 0; i < 16; i++)
        begin
            written[i] = '0;
            order[i] = i;
        end
        for (int i = 15; i > 0; i--)
        begin
            tmp = $urandom_range(i);
            a = order[i];
            order[i] = order[tmp];
            order[tmp] = a;
        end
        for (int i = 0; i < 16; i++)
        begin
            order_pos[order[i]] = i;
        end

        repeat (5)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;

        configure(0);
        run_sort();
        set_edge(15, 15, 1'b1);
        set_edge(0, 0, 1'b1);
        configure(1);
        run_sort();
        set_edge(0, 0, 1'b0);
        run_sort();
        configure(16);
        run_sort();
        set_edge(15, 15, 1'b0);
        set_edge(15, 0, 1'b1);
        set_edge(7, 15, 1'b1);
        run_sort();
        configure(32'hFFFF_FFFF);
        run_sort();
        set_edge(15, 0, 1'b0);
        set_edge(7, 15, 1'b0);

        for (int ph = 0; ph < 8; ph++)
        begin
            cfg = (ph == 5) ? $urandom_range(2, 15) : node_counts[ph];
            configure(cfg);
            steady = (ph == 3);
            span = (cfg < 2) ? 16 : ((cfg > 16) ? 16 : cfg);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                while (undo_rows.size() > 0)
                begin
                    set_edge(undo_rows.pop_front(), undo_cols.pop_front(), 1'b0);
                end
                repeat ($urandom_range(0, 8))
                begin
                    pick = $urandom_range(99);
                    a = $urandom_range(span - 1);
                    b = $urandom_range(span - 1);
                    if (a == b)
                    begin
                        b = (a + 1) % span;
                    end
                    if (pick < 55)
                    begin
                        if (order_pos[a] < order_pos[b])
                        begin
                            tmp = a;
                            a = b;
                            b = tmp;
                        end
                        set_edge(a, b, 1'b1);
                    end
                    else if (pick < 80)
                    begin
                        tries = 0;
                        while (tries < 32 && !written[a][b])
                        begin
                            a = $urandom_range(span - 1);
                            b = $urandom_range(span - 1);
                            tries++;
                        end
                        set_edge(a, b, 1'b0);
                    end
                    else if (pick < 92)
                    begin
                        a = $urandom_range(15);
                        b = $urandom_range(15);
                        e = 1'($urandom);
                        set_edge(a, b, e);
                        if (e)
                        begin
                            undo_rows = {undo_rows, a};
                            undo_cols = {undo_cols, b};
                        end
                    end
                    else
                    begin
                        if (pick < 95)
                        begin
                            b = a;
                        end
                        else if (order_pos[a] > order_pos[b])
                        begin
                            tmp = a;
                            a = b;
                            b = tmp;
                        end
                        set_edge(a, b, 1'b1);
                        undo_rows = {undo_rows, a};
                        undo_cols = {undo_cols, b};
                    end
                end
                run_sort();
            end
        end
        steady = 1'b0;

        drain();
        if (fail_count == 0 && pending == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
